// File: rtl/quadrature_and_button_counter_defines.svh
// Assertion helpers for the counter checker.
`ifndef QUADRATURE_AND_BUTTON_COUNTER_DEFINES_SVH
`define QUADRATURE_AND_BUTTON_COUNTER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define QBC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define QBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/qbc_pkg.sv
`default_nettype none
package qbc_pkg;

  localparam int MAX_BUTTONS          = 8;
  localparam int DEFAULT_BUTTON_COUNT = 8;
  localparam int DIGIT_COUNT          = 4;
  localparam int COUNT_WIDTH          = 10;
  localparam int SEG_WIDTH            = 8;
  localparam int HIST_WIDTH           = 13;

  localparam logic [HIST_WIDTH-1:0]  HIST_PRESS  = 13'h1000;
  localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = 10'd1023;
  localparam logic [SEG_WIDTH-1:0]   SEG_BLANK   = 8'hFF;
  localparam logic [SEG_WIDTH-1:0]   SEG_COLON   = 8'h07;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_A_LOW  = 2'd1,
    PH_DETENT = 2'd2,
    PH_B_LOW  = 2'd3
  } enc_phase_t;

  typedef struct packed {
    logic up;
    logic down;
  } enc_step_t;

  typedef logic [SEG_WIDTH-1:0] seg_digits_t [DIGIT_COUNT];

  function automatic logic [SEG_WIDTH-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_WIDTH-1:0] code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h98;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// File: rtl/qbc_button_lane.sv
`default_nettype none
module qbc_button_lane (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic level,
  output logic      press
);

  logic [qbc_pkg::HIST_WIDTH-1:0] history;
  logic [qbc_pkg::HIST_WIDTH-1:0] history_next;

  assign history_next = {history[qbc_pkg::HIST_WIDTH-2:0], level};
  // one released sample, then a full run of pressed samples
  assign press = (history_next == qbc_pkg::HIST_PRESS);

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (en) begin
      history <= history_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/qbc_encoder.sv
`default_nettype none
module qbc_encoder (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         a,
  input  wire logic         b,
  output qbc_pkg::enc_step_t step
);

  qbc_pkg::enc_phase_t phase;
  qbc_pkg::enc_phase_t phase_next;
  logic signed [2:0]   steps;
  logic signed [2:0]   steps_next;
  logic                last_a;
  logic                last_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= qbc_pkg::PH_IDLE;
      steps  <= '0;
      last_a <= 1'b1;
      last_b <= 1'b1;
    end else if (en) begin
      phase  <= phase_next;
      steps  <= steps_next;
      last_a <= a;
      last_b <= b;
    end
  end

  always_comb begin
    logic signed [3:0] acc;
    phase_next = phase;
    acc        = {steps[2], steps};
    step       = '0;
    case (phase)
      qbc_pkg::PH_IDLE: begin
        step.up   = (steps == 3'sd3);
        step.down = (steps == -3'sd3);
        acc       = '0;
        if (a != last_a || b != last_b) begin
          if (!a && b) begin
            if (last_a) begin
              phase_next = qbc_pkg::PH_A_LOW;
              acc        = 4'sd1;
            end
          end else if (a && !b) begin
            if (last_b) begin
              phase_next = qbc_pkg::PH_B_LOW;
              acc        = -4'sd1;
            end
          end
        end
      end
      qbc_pkg::PH_A_LOW: begin
        if (!a && !b) begin
          if (last_b) begin
            phase_next = qbc_pkg::PH_DETENT;
            acc        = acc + 4'sd1;
          end
        end else if (a && b) begin
          if (!last_a) phase_next = qbc_pkg::PH_IDLE;
        end
      end
      qbc_pkg::PH_DETENT: begin
        if (a && !b) begin
          if (!last_a) begin
            phase_next = qbc_pkg::PH_B_LOW;
            acc        = acc + 4'sd1;
          end
        end else if (!a && b) begin
          if (!last_b) begin
            phase_next = qbc_pkg::PH_A_LOW;
            acc        = acc - 4'sd1;
          end
        end
      end
      default: begin
        if (a && b) begin
          if (!last_b) phase_next = qbc_pkg::PH_IDLE;
        end else if (!a && !b) begin
          if (last_a) begin
            phase_next = qbc_pkg::PH_DETENT;
            acc        = acc - 4'sd1;
          end
        end
      end
    endcase
    if (acc > 4'sd3) begin
      steps_next = 3'sd3;
    end else if (acc < -4'sd3) begin
      steps_next = -3'sd3;
    end else begin
      steps_next = acc[2:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/qbc_display.sv
`default_nettype none
module qbc_display (
  input  wire logic [qbc_pkg::COUNT_WIDTH-1:0] value,
  output qbc_pkg::seg_digits_t                 digits
);

  localparam int W = qbc_pkg::COUNT_WIDTH;

  always_comb begin
    logic [W-1:0] r1;
    logic [W-1:0] r2;
    logic [W-1:0] r3;
    logic         th;
    logic [3:0]   hd;
    logic [3:0]   td;
    th = (value >= W'(1000));
    r1 = th ? value - W'(1000) : value;
    hd = '0;
    for (int k = 1; k < 10; k++) begin
      if (r1 >= W'(k * 100)) hd = 4'(k);
    end
    r2 = r1 - W'(hd) * W'(100);
    td = '0;
    for (int k = 1; k < 10; k++) begin
      if (r2 >= W'(k * 10)) td = 4'(k);
    end
    r3 = r2 - W'(td) * W'(10);
    digits[0] = qbc_pkg::seg_code(r3[3:0]);
    digits[1] = (value < W'(10))   ? qbc_pkg::SEG_BLANK : qbc_pkg::seg_code(td);
    digits[2] = (value < W'(100))  ? qbc_pkg::SEG_BLANK : qbc_pkg::seg_code(hd);
    digits[3] = (value < W'(1000)) ? qbc_pkg::SEG_BLANK : qbc_pkg::seg_code({3'b000, th});
  end

endmodule
`default_nettype wire

// File: rtl/quadrature_and_button_counter.sv
`default_nettype none
// Scan-tick counter: each request carries eight active-low button levels and
// the two encoder pins, and yields one result with the updated count, the
// four digit segment codes (leading zeros blanked, units always shown), the
// fixed colon code and the mask of presses found on that tick. A request is
// taken every cycle unless the input is stalled; its result reaches the outputs
// through the debounce lanes, encoder machine and count update in the first stage
// and the digit split in the second. Backpressure on the result side stalls the
// input only once both stages hold work. count_limit may be written only when
// idle; sums above it, and steps below zero, give a count of zero.
module quadrature_and_button_counter #(
  parameter int BUTTON_COUNT = qbc_pkg::DEFAULT_BUTTON_COUNT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write_en,
  input  wire logic [qbc_pkg::COUNT_WIDTH-1:0]  cfg_write_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [qbc_pkg::MAX_BUTTONS-1:0]  button_levels,
  input  wire logic                             enc_a,
  input  wire logic                             enc_b,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [qbc_pkg::COUNT_WIDTH-1:0]       count_value,
  output logic [qbc_pkg::SEG_WIDTH-1:0]         ones_segments,
  output logic [qbc_pkg::SEG_WIDTH-1:0]         tens_segments,
  output logic [qbc_pkg::SEG_WIDTH-1:0]         colon_segments,
  output logic [qbc_pkg::SEG_WIDTH-1:0]         hundreds_segments,
  output logic [qbc_pkg::SEG_WIDTH-1:0]         thousands_segments,
  output logic [qbc_pkg::MAX_BUTTONS-1:0]       press_mask
);

  localparam int CW = qbc_pkg::COUNT_WIDTH;
  localparam int NB = qbc_pkg::MAX_BUTTONS;
  localparam int SW = CW + 2;

  logic                 in_accept;
  logic                 s1_adv;
  logic                 s1_valid;
  logic [NB-1:0]        s1_mask;
  logic [CW-1:0]        count_limit;
  logic [CW-1:0]        counter;
  logic [CW-1:0]        counter_next;
  logic [NB-1:0]        press;
  qbc_pkg::enc_step_t   step;
  qbc_pkg::seg_digits_t digits;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] delta;

  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  for (genvar i = 0; i < NB; i++) begin : g_lane
    if (i < BUTTON_COUNT) begin : g_on
      qbc_button_lane u_lane (
        .clk   (clk),
        .rst   (rst),
        .en    (in_accept),
        .level (button_levels[i]),
        .press (press[i])
      );
    end else begin : g_off
      assign press[i] = 1'b0;
    end
  end

  qbc_encoder u_encoder (
    .clk  (clk),
    .rst  (rst),
    .en   (in_accept),
    .a    (enc_a),
    .b    (enc_b),
    .step (step)
  );

  // press mask doubles as the weighted button sum
  always_comb begin
    delta = step.up ? SW'(1) : (step.down ? -SW'(1) : '0);
    sum   = $signed({{(SW-CW){1'b0}}, counter}) + $signed({{(SW-NB){1'b0}}, press}) + delta;
    if (sum[SW-1] || (sum[SW-2:0] > {1'b0, count_limit})) begin
      counter_next = '0;
    end else begin
      counter_next = sum[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit <= qbc_pkg::LIMIT_RESET;
    end else if (cfg_write_en) begin
      count_limit <= cfg_write_data;
    end
  end

  // counter also serves as the first-stage count: it only moves when stage one moves
  always_ff @(posedge clk) begin
    if (rst) begin
      counter  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_accept) counter <= counter_next;
      s1_valid <= in_accept || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_mask <= press;
  end

  qbc_display u_display (
    .value  (counter),
    .digits (digits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_adv || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      count_value        <= counter;
      ones_segments      <= digits[0];
      tens_segments      <= digits[1];
      hundreds_segments  <= digits[2];
      thousands_segments <= digits[3];
      press_mask         <= s1_mask;
    end
  end

  assign colon_segments = qbc_pkg::SEG_COLON;

endmodule
`default_nettype wire

// File: rtl/qbc_checker.sv
`default_nettype none
`include "quadrature_and_button_counter_defines.svh"
module qbc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [qbc_pkg::COUNT_WIDTH-1:0] count_value,
  input wire logic [qbc_pkg::SEG_WIDTH-1:0]   ones_segments,
  input wire logic [qbc_pkg::SEG_WIDTH-1:0]   tens_segments,
  input wire logic [qbc_pkg::SEG_WIDTH-1:0]   colon_segments,
  input wire logic [qbc_pkg::SEG_WIDTH-1:0]   hundreds_segments,
  input wire logic [qbc_pkg::SEG_WIDTH-1:0]   thousands_segments
);

  `QBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(count_value), "result dropped or changed while stalled")
  `QBC_ASSERT_IMPL(a_zero_blank, out_valid && count_value == '0, tens_segments == qbc_pkg::SEG_BLANK && hundreds_segments == qbc_pkg::SEG_BLANK && thousands_segments == qbc_pkg::SEG_BLANK, "zero count not blanked")
  `QBC_ASSERT_IMPL(a_units_shown, out_valid, ones_segments != qbc_pkg::SEG_BLANK && colon_segments == qbc_pkg::SEG_COLON, "units or colon code wrong")
  `QBC_ASSERT_IMPL(a_thousands, out_valid && count_value < 10'd1000, thousands_segments == qbc_pkg::SEG_BLANK, "thousands digit shown below 1000")

endmodule

bind quadrature_and_button_counter qbc_checker u_checker (.*);
`default_nettype wire

// File: bench/quadrature_and_button_counter_checker.sv
module quadrature_and_button_counter_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [qbc_pkg::COUNT_WIDTH-1:0] cfg_write_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [qbc_pkg::MAX_BUTTONS-1:0] button_levels,
  input  logic                            enc_a,
  input  logic                            enc_b,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [qbc_pkg::COUNT_WIDTH-1:0] count_value,
  input  logic [qbc_pkg::SEG_WIDTH-1:0]   ones_segments,
  input  logic [qbc_pkg::SEG_WIDTH-1:0]   tens_segments,
  input  logic [qbc_pkg::SEG_WIDTH-1:0]   colon_segments,
  input  logic [qbc_pkg::SEG_WIDTH-1:0]   hundreds_segments,
  input  logic [qbc_pkg::SEG_WIDTH-1:0]   thousands_segments,
  input  logic [qbc_pkg::MAX_BUTTONS-1:0] press_mask,
  output int                              fail_count,
  output int                              pending,
  output int                              checked,
  output int                              presses
);
  import qbc_pkg::*;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic [SEG_WIDTH-1:0]   ones;
    logic [SEG_WIDTH-1:0]   tens;
    logic [SEG_WIDTH-1:0]   hundreds;
    logic [SEG_WIDTH-1:0]   thousands;
    logic [MAX_BUTTONS-1:0] mask;
  } display_t;

  localparam logic [SEG_WIDTH-1:0] DIGIT_PATTERN [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
  };

  logic [HIST_WIDTH-1:0]  lane_hist [MAX_BUTTONS];
  enc_phase_t             knob_phase;
  int                     knob_steps;
  logic                   prev_a;
  logic                   prev_b;
  logic [COUNT_WIDTH-1:0] tally;
  logic [COUNT_WIDTH-1:0] tally_limit;
  display_t               display_q [$];
  display_t               due;

  // Detent machine; returns the count step owed by a finished detent cycle.
  function automatic int knob_step(input logic a, input logic b);
    int delta;
    delta = 0;
    case (knob_phase)
      PH_IDLE: begin
        if (knob_steps == 3) delta = 1;
        else if (knob_steps == -3) delta = -1;
        knob_steps = 0;
        if (a != prev_a || b != prev_b) begin
          if (!a && b) begin
            if (prev_a) begin
              knob_phase = PH_A_LOW;
              knob_steps++;
            end
          end else if (a && !b) begin
            if (prev_b) begin
              knob_phase = PH_B_LOW;
              knob_steps--;
            end
          end
        end
      end
      PH_A_LOW: begin
        if (!a && !b) begin
          if (prev_b) begin
            knob_phase = PH_DETENT;
            knob_steps++;
          end
        end else if (a && b) begin
          if (!prev_a) knob_phase = PH_IDLE;
        end
      end
      PH_DETENT: begin
        if (a && !b) begin
          if (!prev_a) begin
            knob_phase = PH_B_LOW;
            knob_steps++;
          end
        end else if (!a && b) begin
          if (!prev_b) begin
            knob_phase = PH_A_LOW;
            knob_steps--;
          end
        end
      end
      default: begin
        if (a && b) begin
          if (!prev_b) knob_phase = PH_IDLE;
        end else if (!a && !b) begin
          if (prev_a) begin
            knob_phase = PH_DETENT;
            knob_steps--;
          end
        end
      end
    endcase
    if (knob_steps > 3) knob_steps = 3;
    if (knob_steps < -3) knob_steps = -3;
    prev_a = a;
    prev_b = b;
    return delta;
  endfunction

  function automatic display_t predict_tick(input logic [MAX_BUTTONS-1:0] levels,
                                            input logic a, input logic b);
    int                    sum;
    int                    v;
    logic [HIST_WIDTH-1:0] h;
    logic [SEG_WIDTH-1:0]  digs [DIGIT_COUNT];
    display_t              r;
    sum = tally;
    r = '0;
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      h = {lane_hist[i][HIST_WIDTH-2:0], levels[i]};
      lane_hist[i] = h;
      if (h == HIST_PRESS) begin
        r.mask[i] = 1'b1;
        sum += 1 << i;
      end
    end
    sum += knob_step(a, b);
    if (sum < 0 || sum > int'(tally_limit)) sum = 0;
    tally = sum[COUNT_WIDTH-1:0];
    v = tally;
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      digs[d] = (d == 0 || v != 0) ? DIGIT_PATTERN[v % 10] : SEG_BLANK;
      v = v / 10;
    end
    r.count     = tally;
    r.ones      = digs[0];
    r.tens      = digs[1];
    r.hundreds  = digs[2];
    r.thousands = digs[3];
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BUTTONS; i++) lane_hist[i] = '0;
      knob_phase  = PH_IDLE;
      knob_steps  = 0;
      prev_a      = 1'b1;
      prev_b      = 1'b1;
      tally       = '0;
      tally_limit = LIMIT_RESET;
      display_q.delete();
      fail_count  = 0;
      checked     = 0;
      presses     = 0;
      pending    <= 0;
    end else begin
      if (cfg_write_en) tally_limit = cfg_write_data;
      if (out_valid && out_ready) begin
        if (display_q.size() == 0) begin
          $error("result with no request waiting: count_value %0d", count_value);
          fail_count++;
        end else begin
          due = display_q.pop_front();
          check_field("count_value", due.count, count_value);
          check_field("ones_segments", due.ones, ones_segments);
          check_field("tens_segments", due.tens, tens_segments);
          check_field("colon_segments", SEG_COLON, colon_segments);
          check_field("hundreds_segments", due.hundreds, hundreds_segments);
          check_field("thousands_segments", due.thousands, thousands_segments);
          check_field("press_mask", due.mask, press_mask);
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        due = predict_tick(button_levels, enc_a, enc_b);
        presses += $countones(due.mask);
        display_q.push_back(due);
      end
      pending <= display_q.size();
    end
  end

endmodule

// File: bench/quadrature_and_button_counter_tb.sv
module quadrature_and_button_counter_tb;
  import qbc_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write_en;
  logic [COUNT_WIDTH-1:0] cfg_write_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [MAX_BUTTONS-1:0] button_levels;
  logic                   enc_a;
  logic                   enc_b;
  logic                   out_valid;
  logic                   out_ready;
  logic [COUNT_WIDTH-1:0] count_value;
  logic [SEG_WIDTH-1:0]   ones_segments;
  logic [SEG_WIDTH-1:0]   tens_segments;
  logic [SEG_WIDTH-1:0]   colon_segments;
  logic [SEG_WIDTH-1:0]   hundreds_segments;
  logic [SEG_WIDTH-1:0]   thousands_segments;
  logic [MAX_BUTTONS-1:0] press_mask;

  int fail_count;
  int pending;
  int checked;
  int presses;

  int   ticks_sent;
  int   limits_used;
  int   stim_phase;
  bit   quiet;
  bit   held_long;
  logic lane_level [MAX_BUTTONS];
  int   lane_run [MAX_BUTTONS];
  logic [1:0] knob_idx;
  bit   knob_dir;

  int phase_limit [6] = '{0, 1023, 99, 1000, -1, 1023};

  quadrature_and_button_counter dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .button_levels      (button_levels),
    .enc_a              (enc_a),
    .enc_b              (enc_b),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .count_value        (count_value),
    .ones_segments      (ones_segments),
    .tens_segments      (tens_segments),
    .colon_segments     (colon_segments),
    .hundreds_segments  (hundreds_segments),
    .thousands_segments (thousands_segments),
    .press_mask         (press_mask)
  );

  quadrature_and_button_counter_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .button_levels      (button_levels),
    .enc_a              (enc_a),
    .enc_b              (enc_b),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .count_value        (count_value),
    .ones_segments      (ones_segments),
    .tens_segments      (tens_segments),
    .colon_segments     (colon_segments),
    .hundreds_segments  (hundreds_segments),
    .thousands_segments (thousands_segments),
    .press_mask         (press_mask),
    .fail_count         (fail_count),
    .pending            (pending),
    .checked            (checked),
    .presses            (presses)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("quadrature_and_button_counter test failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_tick(input logic [MAX_BUTTONS-1:0] lv, input logic a, input logic b);
    int g;
    g = quiet ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid      <= 1'b1;
    button_levels <= lv;
    enc_a         <= a;
    enc_b         <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Buttons: released and pressed runs, mostly long enough to register, some bounce.
  // Knob: walks the gray cycle with holds, reversals and the odd glitch.
  task automatic random_tick();
    logic [MAX_BUTTONS-1:0] lv;
    logic [1:0]             ab;
    int                     r;
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      if (lane_run[i] == 0) begin
        lane_level[i] = ~lane_level[i];
        if (lane_level[i]) lane_run[i] = $urandom_range(1, 20);
        else if ($urandom_range(0, 3) != 0) lane_run[i] = $urandom_range(12, 25);
        else lane_run[i] = $urandom_range(1, 11);
      end
      lane_run[i]--;
      lv[i] = lane_level[i];
    end
    if ($urandom_range(0, 24) == 0) lv[$urandom_range(0, MAX_BUTTONS - 1)] ^= 1'b1;
    r = $urandom_range(0, 99);
    if (r >= 45 && r < 95) begin
      if (r < 50) knob_dir = ~knob_dir;
      knob_idx = knob_dir ? knob_idx + 2'd1 : knob_idx - 2'd1;
    end
    case (knob_idx)
      2'd0:    ab = 2'b11;
      2'd1:    ab = 2'b01;
      2'd2:    ab = 2'b00;
      default: ab = 2'b10;
    endcase
    if (r >= 95) ab = 2'($urandom_range(0, 3));
    send_tick(lv, ab[1], ab[0]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [COUNT_WIDTH-1:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    limits_used++;
  endtask

  // Result side: random ready runs, plus one long hold-off while requests keep coming.
  initial begin
    int run;
    int g;
    out_ready = 1'b0;
    held_long = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_long && stim_phase >= 2) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        held_long = 1'b1;
      end
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 30);
      repeat (run) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    button_levels  = '1;
    enc_a          = 1'b1;
    enc_b          = 1'b1;
    ticks_sent     = 0;
    limits_used    = 1;
    stim_phase     = 0;
    quiet          = 1'b0;
    knob_idx       = 2'd0;
    knob_dir       = 1'b1;
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      lane_level[i] = 1'b1;
      lane_run[i]   = $urandom_range(1, 20);
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reverse detent from zero, all buttons pressed together, forward detent
    send_tick(8'hFF, 1'b1, 1'b1);
    send_tick(8'hFF, 1'b1, 1'b0);
    send_tick(8'hFF, 1'b0, 1'b0);
    send_tick(8'hFF, 1'b0, 1'b1);
    send_tick(8'hFF, 1'b1, 1'b1);
    send_tick(8'hFF, 1'b1, 1'b1);
    send_tick(8'h00, 1'b0, 1'b1);
    send_tick(8'h00, 1'b0, 1'b0);
    send_tick(8'h00, 1'b1, 1'b0);
    send_tick(8'h00, 1'b1, 1'b1);
    repeat (8) send_tick(8'h00, 1'b1, 1'b1);
    send_tick(8'hAA, 1'b0, 1'b1);
    send_tick(8'h55, 1'b1, 1'b0);

    for (int p = 0; p < 6; p++) begin
      settle();
      write_limit(phase_limit[p] < 0 ? 10'($urandom_range(0, 1023)) : 10'(phase_limit[p]));
      stim_phase = p + 1;
      quiet = ($urandom_range(0, 3) == 0);
      repeat (310) random_tick();
    end
    settle();
    repeat (8) @(posedge clk);

    $display("Ran %0d scan ticks under %0d count_limit settings, 0 and 1023 among them.",
             ticks_sent, limits_used);
    $display("Checked %0d results with %0d debounced presses.", checked, presses);
    if (fail_count == 0) begin
      $display("quadrature_and_button_counter test passed");
    end else begin
      $display("quadrature_and_button_counter test failed");
    end
    $finish;
  end

endmodule
